/* hdl/heading_turn_tracker_defines.svh */
// ----------------------------------------------------------------------------
// heading_turn_tracker_defines: assertion macros
// Shared assertion helpers. Every module that uses them has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef HEADING_TURN_TRACKER_DEFINES_SVH
`define HEADING_TURN_TRACKER_DEFINES_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define HTT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("htt assertion failed");

// antecedent implies consequent in the same cycle
`define HTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htt assertion failed");

// antecedent implies consequent in the next cycle
`define HTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htt assertion failed");

`else

`define HTT_ASSERT(lbl, cond)
`define HTT_ASSERT_IMP(lbl, ante, cons)
`define HTT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/htt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htt_pkg: heading turn tracker package
// Types, codes and fixed-point constants shared by the tracker modules.
// ----------------------------------------------------------------------------
package htt_pkg;

  // item selector codes
  localparam logic [1:0] FUNC_YAW  = 2'd0;
  localparam logic [1:0] FUNC_GOAL = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_TURNING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;

  // register indexes (byte address / 4)
  localparam int          ADDR_W         = 4;
  localparam logic [1:0]  REG_USE_CUSTOM = 2'd0;
  localparam logic [1:0]  REG_EXIT       = 2'd1;
  localparam logic [1:0]  REG_ENTRANCE   = 2'd2;
  localparam logic [1:0]  REG_TURN_SPEED = 2'd3;

  // Q3.12 angle constants, 18-bit signed working width
  localparam logic signed [17:0] WRAP_TWO_PI = 18'sd25723;
  localparam logic signed [17:0] STEP_TWO_PI = 18'sd25736;
  localparam logic signed [17:0] LOW_BAND    = 18'sd4096;
  localparam logic signed [17:0] HIGH_BAND   = 18'sd25395;
  localparam logic [16:0]        STEP_LIMIT  = 17'd6431;
  localparam logic [19:0]        TOTAL_MAX   = 20'd524287;

  typedef struct packed {
    logic        use_custom;
    logic [14:0] exit_angle;
    logic [14:0] entrance_angle;
    logic [14:0] turn_speed;
  } htt_cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [14:0] yaw_sample;
    logic signed [15:0] goal_angle;
    logic               enter_row;
  } htt_item_t;

  typedef struct packed {
    logic signed [15:0] angular_speed;
    logic [1:0]         status;
  } htt_res_t;

endpackage

/* hdl/htt_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htt_in_if: input item channel
// Valid/ready channel carrying one tracker input item.
// ----------------------------------------------------------------------------
interface htt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [14:0] yaw_sample;
  logic signed [15:0] goal_angle;
  logic               enter_row;

  modport source (output valid, output func, output yaw_sample, output goal_angle,
                  output enter_row, input ready);
  modport sink   (input valid, input func, input yaw_sample, input goal_angle,
                  input enter_row, output ready);
endinterface

/* hdl/htt_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htt_out_if: result channel
// Valid/ready channel carrying one tracker result item.
// ----------------------------------------------------------------------------
interface htt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angular_speed;
  logic [1:0]         status;

  modport source (output valid, output angular_speed, output status, input ready);
  modport sink   (input valid, input angular_speed, input status, output ready);
endinterface

/* hdl/htt_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htt_cfg_regs: configuration registers
// APB-style register file holding custom angle select, angles and speed.
// ----------------------------------------------------------------------------
module htt_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [htt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output htt_pkg::htt_cfg_t         cfg
);
  import htt_pkg::*;

  htt_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_USE_CUSTOM: cfg_r.use_custom     <= pwdata[0];
        REG_EXIT:       cfg_r.exit_angle     <= pwdata[14:0];
        REG_ENTRANCE:   cfg_r.entrance_angle <= pwdata[14:0];
        REG_TURN_SPEED: cfg_r.turn_speed     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_USE_CUSTOM: prdata = {31'd0, cfg_r.use_custom};
      REG_EXIT:       prdata = {17'd0, cfg_r.exit_angle};
      REG_ENTRANCE:   prdata = {17'd0, cfg_r.entrance_angle};
      REG_TURN_SPEED: prdata = {17'd0, cfg_r.turn_speed};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* hdl/htt_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htt_core: turn tracking datapath
// Holds tracking state; processes one registered item per cycle while item_vld is high.
// ----------------------------------------------------------------------------
`include "heading_turn_tracker_defines.svh"

module htt_core #(
  parameter int DECIMATION = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_vld,
  input  htt_pkg::htt_item_t item,
  input  htt_pkg::htt_cfg_t  cfg,
  output logic               res_vld,
  output htt_pkg::htt_res_t  res
);
  import htt_pkg::*;

  localparam int CNT_W = $clog2(DECIMATION + 1);
  localparam logic [CNT_W-1:0] DEC_N = CNT_W'(DECIMATION);

  // tracking state
  logic               active_r, active_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               have_first_r, have_first_nxt;
  logic signed [15:0] last_r, last_nxt;
  logic [19:0]        total_r, total_nxt;
  logic               step_acc_r, step_acc_nxt;
  logic               side_neg_r, side_neg_nxt;
  logic signed [15:0] goal_r, goal_nxt;
  logic               enter_r, enter_nxt;

  // datapath
  logic [CNT_W-1:0]   cnt_inc;
  logic               tick;
  logic signed [17:0] yaw_x, yaw_w, last_x, diff_a, diff_b;
  logic [16:0]        abs_a, abs_b, step;
  logic               fwd, step_good, acc_new;
  logic [20:0]        total_sum;
  logic [19:0]        total_sat, total_upd;
  logic signed [16:0] goal_x;
  logic [16:0]        mag_goal, mag;
  logic               side_new, done;
  logic signed [15:0] speed;

  assign cnt_inc = cnt_r + 1'b1;
  assign tick    = (cnt_inc >= DEC_N);

  // wrap yaw into 0..2pi
  assign yaw_x  = 18'(item.yaw_sample);
  assign yaw_w  = (yaw_x < 0) ? yaw_x + WRAP_TWO_PI : yaw_x;
  assign last_x = 18'(last_r);

  // shortest step, direct or across the wrap
  assign diff_a = yaw_w - last_x;
  assign diff_b = side_neg_r ? (yaw_w - last_x - STEP_TWO_PI)
                             : (yaw_w - last_x + STEP_TWO_PI);
  assign abs_a  = 17'((diff_a < 0) ? -diff_a : diff_a);
  assign abs_b  = 17'((diff_b < 0) ? -diff_b : diff_b);
  assign step   = (abs_a < abs_b) ? abs_a : abs_b;

  // forward motion in the turning direction, with wrap bands
  always_comb begin
    if (!side_neg_r) begin
      fwd = (last_x < yaw_w) ||
            ((last_x > yaw_w) && (yaw_w < LOW_BAND) && (last_x > HIGH_BAND));
    end else begin
      fwd = (last_x > yaw_w) ||
            ((last_x < yaw_w) && (last_x < LOW_BAND) && (yaw_w > HIGH_BAND));
    end
  end

  assign step_good = (step < STEP_LIMIT) && fwd;
  assign acc_new   = have_first_r ? step_good : step_acc_r;

  // saturating accumulator
  assign total_sum = {1'b0, total_r} + 21'(step);
  assign total_sat = (total_sum > 21'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[19:0];
  assign total_upd = (have_first_r && step_good) ? total_sat : total_r;

  // target magnitude and turning side
  assign goal_x   = 17'(goal_r);
  assign mag_goal = 17'((goal_x < 0) ? -goal_x : goal_x);
  assign mag      = !cfg.use_custom ? mag_goal
                  : (enter_r ? {2'b00, cfg.entrance_angle} : {2'b00, cfg.exit_angle});
  assign side_new = cfg.use_custom && goal_r[15] && (mag != 17'd0);
  assign done     = (total_upd >= 20'(mag));
  assign speed    = side_new ? -16'({1'b0, cfg.turn_speed}) : 16'({1'b0, cfg.turn_speed});

  always_comb begin
    active_nxt     = active_r;
    cnt_nxt        = cnt_r;
    have_first_nxt = have_first_r;
    last_nxt       = last_r;
    total_nxt      = total_r;
    step_acc_nxt   = step_acc_r;
    side_neg_nxt   = side_neg_r;
    goal_nxt       = goal_r;
    enter_nxt      = enter_r;
    res_vld        = 1'b0;
    res            = '{angular_speed: 16'sd0, status: ST_TURNING};
    case (item.func)
      FUNC_GOAL: begin
        goal_nxt       = item.goal_angle;
        enter_nxt      = item.enter_row;
        total_nxt      = '0;
        last_nxt       = '0;
        cnt_nxt        = '0;
        have_first_nxt = 1'b0;
        active_nxt     = 1'b1;
      end
      FUNC_STOP: begin
        active_nxt = 1'b0;
        res_vld    = 1'b1;
        res        = '{angular_speed: 16'sd0, status: ST_STOPPED};
      end
      FUNC_YAW: begin
        if (!tick) begin
          cnt_nxt = cnt_inc;
        end else begin
          cnt_nxt = '0;
          if (active_r) begin
            step_acc_nxt   = acc_new;
            total_nxt      = total_upd;
            have_first_nxt = 1'b1;
            side_neg_nxt   = side_new;
            if (acc_new) begin
              last_nxt = 16'(yaw_w);
            end
            res_vld = 1'b1;
            if (done) begin
              active_nxt = 1'b0;
              res        = '{angular_speed: 16'sd0, status: ST_DONE};
            end else begin
              res = '{angular_speed: speed, status: ST_TURNING};
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      cnt_r        <= '0;
      have_first_r <= 1'b0;
      last_r       <= '0;
      total_r      <= '0;
      step_acc_r   <= 1'b1;
      side_neg_r   <= 1'b0;
      goal_r       <= '0;
      enter_r      <= 1'b0;
    end else if (item_vld) begin
      active_r     <= active_nxt;
      cnt_r        <= cnt_nxt;
      have_first_r <= have_first_nxt;
      last_r       <= last_nxt;
      total_r      <= total_nxt;
      step_acc_r   <= step_acc_nxt;
      side_neg_r   <= side_neg_nxt;
      goal_r       <= goal_nxt;
      enter_r      <= enter_nxt;
    end
  end

  `HTT_ASSERT(a_cnt_range, cnt_r < DEC_N)
  `HTT_ASSERT_NEXT(a_stop_deactivates, item_vld && (item.func == FUNC_STOP), !active_r)
  `HTT_ASSERT_NEXT(a_goal_clears, item_vld && (item.func == FUNC_GOAL),
                   active_r && (total_r == 20'd0) && !have_first_r)

endmodule

/* hdl/heading_turn_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_turn_tracker: in-place turn tracker
// Follows a turn from decimated yaw samples and commands angular speed.
// ----------------------------------------------------------------------------
// usage
//   in_ch  : valid/ready items; func selects yaw sample, new goal or stop
//   out_ch : valid/ready results (angular_speed, status), at most one per item
//   psel.. : APB-style register port, use_custom_angles at 0x0, exit_angle at
//            0x4, entrance_angle at 0x8, turn_speed at 0xc; write config only
//            while no item is in flight
// timing
//   an item is taken into an input register, then processed by the tracking
//   datapath whose result lands in the output register; result valid comes
//   from the output register
//   one item per cycle is sustained while out_ch takes results; the rate is
//   set by the state update in htt_core (accumulate, compare, latch)
// reset
//   synchronous active-low rst_n clears the valid flags, config registers and
//   tracking state; block is inactive until a goal item arrives
// back-pressure
//   while a result waits on out_ch the input register holds its item; in_ch
//   ready drops only when both registers are full and out_ch is stalled
// ----------------------------------------------------------------------------
`include "heading_turn_tracker_defines.svh"

module heading_turn_tracker #(
  parameter int DECIMATION = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  htt_in_if.sink                     in_ch,
  htt_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [htt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import htt_pkg::*;

  htt_cfg_t  cfg;

  // input register stage
  logic      in_vld_r;
  htt_item_t item_r;

  // result register stage
  logic      out_vld_r;
  htt_res_t  res_r;

  // core hookup
  logic      core_res_vld;
  htt_res_t  core_res;
  logic      out_free;
  logic      adv;

  // result slot is free when empty or being taken this cycle
  assign out_free     = !out_vld_r || out_ch.ready;
  // registered item moves through the datapath when the result slot is free
  assign adv          = in_vld_r && out_free;
  assign in_ch.ready  = !in_vld_r || out_free;

  htt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htt_core #(
    .DECIMATION (DECIMATION)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (adv),
    .item     (item_r),
    .cfg      (cfg),
    .res_vld  (core_res_vld),
    .res      (core_res)
  );

  // input register: load on transfer, drain when the item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{func: in_ch.func, yaw_sample: in_ch.yaw_sample,
                  goal_angle: in_ch.goal_angle, enter_row: in_ch.enter_row};
    end
  end

  // result register: items with no result leave the slot empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= core_res_vld;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && core_res_vld) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.angular_speed = res_r.angular_speed;
  assign out_ch.status        = res_r.status;

  // a waiting result is never overwritten
  `HTT_ASSERT_IMP(a_no_overwrite, out_vld_r && !out_ch.ready, !adv)
  // finished or stopped turns always command zero speed
  `HTT_ASSERT_IMP(a_idle_zero_speed, out_vld_r && (res_r.status != ST_TURNING),
                  res_r.angular_speed == 16'sd0)
  // a stalled input item stays in its register
  `HTT_ASSERT_NEXT(a_item_held, in_vld_r && !out_free, in_vld_r && $stable(item_r))

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: heading turn tracker testbench
// Drives goal, yaw, stop and unused items through the valid/ready input
// channel and predicts every speed/status result with a cycle-free model of
// the turn tracker. Each result transfer is checked against the oldest
// prediction. Registers go through several settings over the APB-style port,
// each write read back. Both channels idle and stall in random bursts, except
// in the final phase.
// ----------------------------------------------------------------------------
module testbench;
  import htt_pkg::*;

  localparam int         DECIMATION   = 10;
  localparam logic [1:0] FUNC_NONE    = 2'd3;   // unused selector, no effect
  localparam int         YAW_WRAP     = 25723;  // 2pi used to wrap negative yaw
  localparam int         STEP_WRAP    = 25736;  // 2pi used for the step across zero
  localparam int         STEP_MAX     = 6431;   // steps at or above this are dropped
  localparam int         LOW_EDGE     = 4096;
  localparam int         HIGH_EDGE    = 25395;
  localparam int         TOTAL_CAP    = 524287;
  localparam int         DRAIN_CYCLES = 6;      // covers items still in flight
  localparam int         STALL_LIMIT  = 2000;   // cycles without any transfer
  localparam int         MAX_REPORTS  = 10;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  htt_in_if  in_ch ();
  htt_out_if out_ch ();

  heading_turn_tracker #(
    .DECIMATION(DECIMATION)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // turn tracking model state
  bit  trk_active;
  bit  trk_have_first;
  bit  trk_step_ok;
  bit  trk_side_neg;
  bit  trk_enter;
  int  trk_count;
  int  trk_total;
  int  trk_last;
  int  trk_goal;

  // register copies
  bit  cfg_custom;
  int  cfg_exit;
  int  cfg_entrance;
  int  cfg_speed;

  // speed/status commands still to come out of the block, oldest first
  htt_res_t expected_commands[$];

  int mismatch_count;
  int results_checked;
  int items_sent;
  int counted_items;     // goals and items that produce a result
  int reg_writes;
  int idle_cycles;
  int gap_pct;           // chance of an input gap before an item
  int stall_pct;         // chance of a result stall burst

  // random heading walker used to build well-formed turns
  int walk_heading;
  int walk_dir;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int abs_of(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_tracker();
    trk_active     = 1'b0;
    trk_have_first = 1'b0;
    trk_step_ok    = 1'b1;
    trk_side_neg   = 1'b0;
    trk_enter      = 1'b0;
    trk_count      = 0;
    trk_total      = 0;
    trk_last       = 0;
    trk_goal       = 0;
    cfg_custom     = 1'b0;
    cfg_exit       = 0;
    cfg_entrance   = 0;
    cfg_speed      = 0;
  endfunction

  // does the new heading lie ahead of the last one in the turning direction
  function automatic bit heads_forward(input int last, input int yw);
    if (!trk_side_neg) begin
      return (last < yw) || (last > yw && yw < LOW_EDGE && last > HIGH_EDGE);
    end
    return (last > yw) || (last < yw && last < LOW_EDGE && yw > HIGH_EDGE);
  endfunction

  // advances the model by one accepted item, returns the command it causes
  function automatic void track_turn(input htt_item_t it, output bit produces,
                                     output htt_res_t res);
    int yw;
    int near;
    int far;
    int stp;
    int mag;
    produces = 1'b0;
    res = '0;
    case (it.func)
      FUNC_GOAL: begin
        trk_goal       = $signed(it.goal_angle);
        trk_enter      = it.enter_row;
        trk_total      = 0;
        trk_last       = 0;
        trk_count      = 0;
        trk_have_first = 1'b0;
        trk_active     = 1'b1;
      end
      FUNC_STOP: begin
        trk_active = 1'b0;
        res.status = ST_STOPPED;
        produces   = 1'b1;
      end
      FUNC_YAW: begin
        trk_count = (trk_count + 1) & 15;
        if (trk_count >= DECIMATION) begin
          trk_count = 0;
          if (trk_active) begin
            yw = $signed(it.yaw_sample);
            if (yw < 0) yw += YAW_WRAP;
            if (trk_have_first) begin
              near = abs_of(yw - trk_last);
              far  = trk_side_neg ? abs_of(yw - (trk_last + STEP_WRAP))
                                  : abs_of(yw - (trk_last - STEP_WRAP));
              stp  = (near < far) ? near : far;
              trk_step_ok = (stp < STEP_MAX) && heads_forward(trk_last, yw);
              if (trk_step_ok) begin
                trk_total += stp;
                if (trk_total > TOTAL_CAP) trk_total = TOTAL_CAP;
              end
            end
            // a dropped step also keeps the first heading after a goal out
            if (trk_step_ok) trk_last = yw;
            trk_have_first = 1'b1;
            if (!cfg_custom) mag = abs_of(trk_goal);
            else mag = trk_enter ? cfg_entrance : cfg_exit;
            trk_side_neg = cfg_custom && trk_goal < 0 && mag != 0;
            produces = 1'b1;
            if (trk_total >= mag) begin
              trk_active = 1'b0;
              res.status = ST_DONE;
            end else begin
              res.status        = ST_TURNING;
              res.angular_speed = 16'(trk_side_neg ? -cfg_speed : cfg_speed);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endfunction

  function automatic htt_item_t rand_item(input logic [1:0] f);
    htt_item_t it;
    it.func       = f;
    it.yaw_sample = 15'($urandom);
    it.goal_angle = 16'($urandom);
    it.enter_row  = 1'($urandom);
    return it;
  endfunction

  // wrapped heading 0..2pi back to the signed yaw the block receives
  function automatic int yaw_of(input int h);
    return (h > 16383) ? h - YAW_WRAP : h;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, checking of every result transfer
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    htt_res_t want;
    htt_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      got.angular_speed = out_ch.angular_speed;
      got.status        = out_ch.status;
      if (expected_commands.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: speed %0d status %0d",
                                got.angular_speed, got.status));
      end else begin
        want = expected_commands.pop_front();
        if (got.angular_speed !== want.angular_speed || got.status !== want.status)
          note_mismatch($sformatf("expected speed %0d status %0d, got speed %0d status %0d",
                                  want.angular_speed, want.status,
                                  got.angular_speed, got.status));
      end
    end
  end

  // ends the run when neither channel has moved for too long
  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               STALL_LIMIT, expected_commands.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one input transfer, with an optional gap ahead of it; the model advances
  // at the edge that takes the item
  task automatic send_item(input htt_item_t it);
    int       gap;
    bit       produces;
    htt_res_t res;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= it.func;
    in_ch.yaw_sample <= it.yaw_sample;
    in_ch.goal_angle <= it.goal_angle;
    in_ch.enter_row  <= it.enter_row;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    track_turn(it, produces, res);
    items_sent++;
    if (produces) expected_commands.push_back(res);
    if (produces || it.func == FUNC_GOAL) counted_items++;
  endtask

  task automatic send_goal(input int g, input logic e);
    htt_item_t it;
    it = rand_item(FUNC_GOAL);
    it.goal_angle = 16'(g);
    it.enter_row  = e;
    send_item(it);
    walk_dir     = (cfg_custom && $signed(it.goal_angle) < 0) ? -1 : 1;
    walk_heading = $urandom_range(0, YAW_WRAP - 1);
  endtask

  task automatic send_stop();
    send_item(rand_item(FUNC_STOP));
  endtask

  // pads with ignored samples so that this yaw lands on the decimated slot
  task automatic send_heading(input int yaw);
    htt_item_t it;
    while (trk_count != DECIMATION - 1) send_item(rand_item(FUNC_YAW));
    it = rand_item(FUNC_YAW);
    it.yaw_sample = 15'(yaw);
    send_item(it);
  endtask

  // drops valid and lets all pending results and in-flight items drain
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_USE_CUSTOM: cfg_custom   = value[0];
      REG_EXIT:       cfg_exit     = value & 32'h7fff;
      REG_ENTRANCE:   cfg_entrance = value & 32'h7fff;
      REG_TURN_SPEED: cfg_speed    = value & 32'h7fff;
      default: ;
    endcase
    reg_writes++;
    // read it straight back
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== 32'(value))
      note_mismatch($sformatf("register %0d read %0d, written %0d", idx, prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input bit custom, input int ex, input int ent, input int spd);
    wait_idle();
    write_reg(REG_USE_CUSTOM, custom);
    write_reg(REG_EXIT, ex);
    write_reg(REG_ENTRANCE, ent);
    write_reg(REG_TURN_SPEED, spd);
  endtask

  // ---------------------------------------------------------------------------
  // random turns: mostly forward walks toward completion, some dropped or
  // backward steps, goals that restart a turn, stops and unused items;
  // target counts input items, padding samples included
  // ---------------------------------------------------------------------------
  task automatic run_turns(input int target, input int max_mag);
    int stop_at;
    int r;
    int stp;
    int g;
    int yw;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if ((!trk_active && r < 85) || r < 4) begin
        if ($urandom_range(0, 9) == 0) g = $signed(16'($urandom));
        else g = int'($urandom_range(0, max_mag)) * ($urandom_range(0, 1) ? 1 : -1);
        send_goal(g, 1'($urandom));
      end else if (r < 7) begin
        send_stop();
      end else if (r < 9) begin
        send_item(rand_item(FUNC_NONE));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 95) begin
          if (r < 80) stp = walk_dir * int'($urandom_range(0, STEP_MAX - 1));
          else if (r < 88) stp = walk_dir * int'($urandom_range(STEP_MAX - 4, STEP_MAX + 8));
          else stp = -walk_dir * int'($urandom_range(1, 3000));
          walk_heading = (walk_heading + stp % YAW_WRAP + YAW_WRAP) % YAW_WRAP;
          yw = yaw_of(walk_heading);
        end else begin
          // any yaw the field can carry
          yw = $signed(15'($urandom));
          walk_heading = (yw < 0) ? yw + YAW_WRAP : yw;
        end
        send_heading(yw);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // stop, unused selector and yaw samples before any goal
  task automatic test_inactive_items();
    gap_pct   = 20;
    stall_pct = 20;
    set_config(1'b0, 25736, 1, 32767);
    send_stop();                          // stop while inactive still answers
    send_item(rand_item(FUNC_NONE));
    send_heading(1000);                   // decimated sample, but no goal yet
    send_heading(-1000);
  endtask

  // target from the goal magnitude, turn runs positive
  task automatic test_goal_magnitude_turn();
    send_goal(8000, 1'b0);
    send_heading(-16384);                 // most negative yaw, first heading
    send_heading(12339);
    send_heading(16383);                  // most positive yaw
    send_heading(12000);                  // backward, step dropped
    // dropped step: the first heading after this goal is not loaded
    send_goal(2000, 1'b1);
    send_heading(5000);
    send_heading(1500);
    send_heading(3000);                   // reaches the target
    send_heading(100);                    // inactive again, no answer
    send_stop();
  endtask

  // forward step across the 2pi / 0 seam, goal field extremes
  task automatic test_wraparound_turn();
    send_goal(-4000, 1'b0);               // negative goal, still positive turn
    send_heading(-300);
    send_heading(1000);
    send_heading(3800);
    send_goal(-32768, 1'b0);
    send_heading(0);
    send_heading(5000);
    send_stop();                          // stop while turning
    send_goal(32767, 1'b1);
    send_stop();
  endtask

  // custom targets: zero target, negative side, step limit, reverse seam
  task automatic test_custom_angle_turn();
    set_config(1'b1, 20000, 0, 32767);
    send_goal(-1, 1'b1);                  // zero entrance target, done at once
    send_heading(1234);
    send_goal(-100, 1'b0);                // exit target, turning negative
    send_heading(16383);
    send_heading(9952);                   // step exactly at the limit, dropped
    send_heading(9953);                   // one below the limit, kept
    send_heading(3600);
    send_heading(-200);                   // across the seam in the negative turning direction
    send_heading(-3700);
  endtask

  task automatic test_random_goal_turns();
    gap_pct   = 30;
    stall_pct = 30;
    set_config(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767),
               $urandom_range(0, 32767));
    run_turns(200, 12000);
  endtask

  task automatic test_random_custom_turns();
    gap_pct   = 15;
    stall_pct = 45;
    set_config(1'b1, $urandom_range(0, 12000), $urandom_range(0, 12000), 0);
    run_turns(100, 12000);
    gap_pct   = 45;
    stall_pct = 10;
    set_config(1'b1, 32767, 0, $urandom_range(0, 32767));
    run_turns(100, 12000);
  endtask

  // back-to-back transfers on both sides
  task automatic test_unthrottled_turns();
    gap_pct   = 0;
    stall_pct = 0;
    set_config(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767), 32767);
    run_turns(110, 25736);
    set_config(1'b1, 0, 32767, $urandom_range(0, 32767));
    run_turns(110, 25736);
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_YAW;
    in_ch.yaw_sample = '0;
    in_ch.goal_angle = '0;
    in_ch.enter_row  = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    gap_pct          = 0;
    stall_pct        = 0;
    walk_heading     = 0;
    walk_dir         = 1;
    clear_tracker();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_inactive_items();
    test_goal_magnitude_turn();
    test_wraparound_turn();
    test_custom_angle_turn();
    test_random_goal_turns();
    test_random_custom_turns();
    test_unthrottled_turns();

    wait_idle();
    $display("sent %0d items (%0d goals, stops and decimated samples), %0d register writes",
             items_sent, counted_items, reg_writes);
    $display("checked %0d speed/status results, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
